// ===== design/hdhp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hdhp_pkg : shared types and constants for the direction histogram
// Bin geometry, command codes, sequencer states and divider request/response types.
// ---------------------------------------------------------------------------
package hdhp_pkg;
    localparam int PHI_BINS      = 64;
    localparam int COSTHETA_BINS = 32;
    localparam int PHI_W         = $clog2(PHI_BINS);
    localparam int CT_W          = $clog2(COSTHETA_BINS);
    localparam int NBINS         = PHI_BINS * COSTHETA_BINS;
    localparam int ADDR_W        = PHI_W + CT_W;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_PEAK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_FILL_RD, ST_FILL_WR, ST_SCAN, ST_SCAN_END,
        ST_WIN, ST_WIN_END, ST_DIV_PHI, ST_DIV_CT, ST_DIV_H, ST_DONE
    } t_state;

    // divider request / status between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;   // non-negative numerator
        logic [63:0] den;   // positive denominator
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [63:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

// ===== design/hdhp_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hdhp_div : shared restoring divider
// One quotient bit per cycle over a 64-bit quotient.
// ---------------------------------------------------------------------------
module hdhp_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  hdhp_pkg::t_div_req     i_req,
    output hdhp_pkg::t_div_rsp     o_rsp
);
    logic [63:0] r_quo, n_quo;
    logic [64:0] r_rem, n_rem;
    logic [63:0] r_den, n_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [64:0] w_sh;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem[63:0], r_quo[63]};
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = w_sh - {1'b0, r_den};
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[63:0];

`ifndef SYNTH
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    a_rem_lt_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < {1'b0, r_den})) else $error("remainder too large");
    a_cnt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 7'd0) |-> !r_busy) else $error("divider count mismatch");
`endif
endmodule
`default_nettype wire

// ===== design/hough_direction_histogram_peak.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hough_direction_histogram_peak : 2-D direction histogram with peak finder
// Clear / fill / find-peak over a phi x cos(theta) weighted histogram.
// ---------------------------------------------------------------------------
// One command is taken per start beat while busy is low. The block then
// stays busy until the command is done; unused command 3 leaves it idle.
// - Fill: bin read, saturating write back, then idle.
// - Clear: sweeps the bin memory one entry a cycle, writing zeros. A clear
//   also runs straight after reset, so busy is high until that sweep ends.
// - Find-peak: scans all 2048 bins one per memory read, then reads the
//   5x5 window. It then runs five divisions in turn on one shared serial
//   divider (integer part and rounding for each coordinate, then the mean
//   height). An empty store, or a scan that finds every bin zero, goes
//   straight to the result beat with o_found low.
// The single result beat of a find-peak is shown for one cycle on o_valid
// and cannot be stalled. Clear, fill and unused command 3 give no result.
// ---------------------------------------------------------------------------
module hough_direction_histogram_peak (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_cmd,
    input  wire logic signed [15:0] i_phi_code,
    input  wire logic signed [15:0] i_costheta_code,
    input  wire logic [15:0]        i_weight,
    output logic                    o_valid,
    output logic signed [15:0]      o_peak_phi,
    output logic signed [15:0]      o_peak_costheta,
    output logic [31:0]             o_peak_height,
    output logic                    o_found
);
    localparam int AW  = hdhp_pkg::ADDR_W;
    localparam int PW  = hdhp_pkg::PHI_W;
    localparam int CW  = hdhp_pkg::CT_W;
    localparam int NB  = hdhp_pkg::NBINS;

    // bin memory: one write port, one registered read port
    logic [31:0] r_mem [NB];
    logic [31:0] r_rdata;
    logic [AW-1:0] w_raddr, w_waddr;
    logic          w_we;
    logic [31:0]   w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    hdhp_pkg::t_state r_st, n_st;
    logic [AW:0]   r_cnt, n_cnt;        // sweep counter / window index
    logic [AW-1:0] r_addr, n_addr;      // fill address
    logic [15:0]   r_w, n_w;
    logic [31:0]   r_ecnt, n_ecnt;
    logic [47:0]   r_wtot, n_wtot;
    logic [31:0]   r_best, n_best;
    logic [AW-1:0] r_bidx, n_bidx;
    logic [AW-1:0] r_pidx, n_pidx;      // index of bin now in r_rdata
    logic          r_pv, n_pv;          // r_rdata valid for scan/window
    logic signed [2:0] r_pdx, n_pdx, r_pdy, n_pdy;
    logic [37:0]   r_sw, n_sw;
    logic signed [40:0] r_sx, n_sx, r_sy, n_sy;
    logic [4:0]    r_sn, n_sn;
    logic [63:0]   r_qphi, n_qphi;
    logic [63:0]   r_rphi, n_rphi;
    logic [63:0]   r_qct, n_qct;
    logic [63:0]   r_rct, n_rct;
    logic          r_ov, n_ov;
    logic signed [15:0] r_ophi, n_ophi, r_oct, n_oct;
    logic [31:0]   r_oh, n_oh;
    logic          r_of, n_of;

    hdhp_pkg::t_div_req w_dreq;
    hdhp_pkg::t_div_rsp w_drsp;

    hdhp_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    // binning of the incoming pair
    logic [15:0]   w_up, w_uc;
    logic [PW-1:0] w_xb;
    logic [CW-1:0] w_yb;
    assign w_up = i_phi_code ^ 16'h8000;
    assign w_uc = i_costheta_code ^ 16'h8000;
    assign w_xb = w_up[15 -: PW];
    assign w_yb = w_uc[15 -: CW];

    // window walk: index 0..24 -> dx, dy
    logic signed [2:0] w_dx, w_dy;
    logic [4:0]        w_wi;
    logic [PW-1:0]     w_wx;
    logic signed [CW+1:0] w_wy;
    logic              w_win_ok;
    logic [PW-1:0]     w_xmax;
    logic [CW-1:0]     w_ymax;
    assign w_xmax = r_bidx[AW-1 -: PW];
    assign w_ymax = r_bidx[CW-1:0];
    always_comb begin
        w_wi = r_cnt[4:0];
        unique case (1'b1)
            (w_wi < 5'd5):  w_dx = -3'sd2;
            (w_wi >= 5'd5 && w_wi < 5'd10):  w_dx = -3'sd1;
            (w_wi >= 5'd10 && w_wi < 5'd15): w_dx = 3'sd0;
            (w_wi >= 5'd15 && w_wi < 5'd20): w_dx = 3'sd1;
            default: w_dx = 3'sd2;
        endcase
        w_dy = 3'(signed'(5'(w_wi - 5'(5 * (32'(w_dx) + 2)))) - 3'sd2);
        w_wx = w_xmax + PW'(signed'(w_dx));
        w_wy = $signed({2'b00, w_ymax}) + (CW+2)'(w_dy);
        w_win_ok = (w_wy >= 0) && (w_wy < (CW+2)'(hdhp_pkg::COSTHETA_BINS));
    end

    // saturating fill values
    logic [32:0] w_bsum;
    logic [48:0] w_tsum;
    assign w_bsum = {1'b0, r_rdata} + 33'(r_w);
    assign w_tsum = {1'b0, r_wtot} + 49'(r_w);

    // centroid numerators: (2m+1)*sw + 2*s, offset so numerator is >= 0
    // numerator + K*den with K chosen so it stays non-negative
    logic signed [63:0] w_nphi, w_nct;
    logic [63:0] w_dphi, w_dct;
    assign w_dphi = 64'(r_sw) * 64'(hdhp_pkg::PHI_BINS);
    assign w_dct  = 64'(r_sw) * 64'(hdhp_pkg::COSTHETA_BINS);
    assign w_nphi = $signed(64'({w_xmax, 1'b1}) * 64'(r_sw)) + 64'(r_sx <<< 1)
                    + $signed(w_dphi);
    assign w_nct  = $signed(64'({w_ymax, 1'b1}) * 64'(r_sw)) + 64'(r_sy <<< 1)
                    + $signed(w_dct);

    // rounding: frac = (2*r*32768 + d) / (2d) = floor((r*65536+d)/(2d))
    // = (r*65536 >= d*(2k-1)) style; done by comparing 2*r*32768 vs d
    // directly is not exact, so use remainder compare: since frac < 32769,
    // frac = floor(r*32768/d + 1/2). Compute it with the divider too.
    logic [63:0] w_den_cur;
    always_comb begin
        n_st    = r_st;
        n_cnt   = r_cnt;
        n_addr  = r_addr;
        n_w     = r_w;
        n_ecnt  = r_ecnt;
        n_wtot  = r_wtot;
        n_best  = r_best;
        n_bidx  = r_bidx;
        n_pidx  = r_pidx;
        n_pv    = 1'b0;
        n_pdx   = r_pdx;
        n_pdy   = r_pdy;
        n_sw    = r_sw;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_sn    = r_sn;
        n_qphi  = r_qphi;
        n_rphi  = r_rphi;
        n_qct   = r_qct;
        n_rct   = r_rct;
        n_ov    = 1'b0;
        n_ophi  = r_ophi;
        n_oct   = r_oct;
        n_oh    = r_oh;
        n_of    = r_of;
        w_raddr = r_addr;
        w_waddr = r_cnt[AW-1:0];
        w_we    = 1'b0;
        w_wdata = '0;
        w_dreq  = '0;
        w_den_cur = w_dphi;
        busy    = (r_st != hdhp_pkg::ST_IDLE);
        unique case (r_st)
            hdhp_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (hdhp_pkg::t_cmd'(i_cmd))
                        hdhp_pkg::CMD_CLEAR: begin
                            n_cnt = '0;
                            n_st  = hdhp_pkg::ST_CLEAR;
                        end
                        hdhp_pkg::CMD_FILL: begin
                            n_addr = {w_xb, w_yb};
                            n_w    = i_weight;
                            n_st   = hdhp_pkg::ST_FILL_RD;
                        end
                        hdhp_pkg::CMD_PEAK: begin
                            n_best = '0;
                            n_bidx = '0;
                            n_cnt  = '0;
                            n_sw   = '0;
                            n_sx   = '0;
                            n_sy   = '0;
                            n_sn   = '0;
                            if (r_ecnt == 32'd0 || r_wtot == 48'd0) begin
                                n_st = hdhp_pkg::ST_DONE;
                                n_of = 1'b0;
                            end else begin
                                n_st = hdhp_pkg::ST_SCAN;
                            end
                        end
                        default: n_st = hdhp_pkg::ST_IDLE;
                    endcase
                end
            end
            hdhp_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt[AW-1:0];
                n_cnt   = r_cnt + 1'b1;
                n_ecnt  = '0;
                n_wtot  = '0;
                if (r_cnt == (AW+1)'(NB - 1)) begin
                    n_st = hdhp_pkg::ST_IDLE;
                end
            end
            hdhp_pkg::ST_FILL_RD: begin
                w_raddr = r_addr;
                n_st    = hdhp_pkg::ST_FILL_WR;
            end
            hdhp_pkg::ST_FILL_WR: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = w_bsum[32] ? 32'hFFFF_FFFF : w_bsum[31:0];
                if (r_ecnt != 32'hFFFF_FFFF) begin
                    n_ecnt = r_ecnt + 32'd1;
                end
                n_wtot = w_tsum[48] ? 48'hFFFF_FFFF_FFFF : w_tsum[47:0];
                n_st   = hdhp_pkg::ST_IDLE;
            end
            hdhp_pkg::ST_SCAN, hdhp_pkg::ST_SCAN_END: begin
                if (r_pv && (r_rdata > r_best)) begin
                    n_best = r_rdata;
                    n_bidx = r_pidx;
                end
                if (r_st == hdhp_pkg::ST_SCAN) begin
                    w_raddr = r_cnt[AW-1:0];
                    n_pidx  = r_cnt[AW-1:0];
                    n_pv    = 1'b1;
                    n_cnt   = r_cnt + 1'b1;
                    if (r_cnt == (AW+1)'(NB - 1)) begin
                        n_st = hdhp_pkg::ST_SCAN_END;
                    end
                end else begin
                    n_cnt = '0;
                    if (!(r_pv && (r_rdata > r_best)) && r_best == 32'd0) begin
                        n_of = 1'b0;
                        n_st = hdhp_pkg::ST_DONE;
                    end else begin
                        n_st = hdhp_pkg::ST_WIN;
                    end
                end
            end
            hdhp_pkg::ST_WIN, hdhp_pkg::ST_WIN_END: begin
                if (r_pv) begin
                    n_sw = r_sw + 38'(r_rdata);
                    n_sx = r_sx + 41'(signed'({9'd0, r_rdata}) * 41'(r_pdx));
                    n_sy = r_sy + 41'(signed'({9'd0, r_rdata}) * 41'(r_pdy));
                    n_sn = r_sn + 5'd1;
                end
                if (r_st == hdhp_pkg::ST_WIN) begin
                    w_raddr = {w_wx, w_wy[CW-1:0]};
                    n_pv    = w_win_ok;
                    n_pdx   = w_dx;
                    n_pdy   = w_dy;
                    n_cnt   = r_cnt + 1'b1;
                    if (w_wi == 5'd24) begin
                        n_st = hdhp_pkg::ST_WIN_END;
                    end
                end else begin
                    n_cnt = '0;
                    n_st  = hdhp_pkg::ST_DIV_PHI;
                end
            end
            hdhp_pkg::ST_DIV_PHI: begin
                // cnt 0: start q/r, 1: wait, 2: start frac, 3: wait
                w_den_cur = w_dphi;
                unique case (r_cnt[1:0])
                    2'd0: begin
                        w_dreq.start = 1'b1;
                        w_dreq.num   = w_nphi;
                        w_dreq.den   = w_den_cur;
                        n_cnt = (AW+1)'(1);
                    end
                    2'd1: begin
                        if (w_drsp.done) begin
                            n_qphi = w_drsp.quo;
                            n_rphi = w_drsp.rem;
                            n_cnt  = (AW+1)'(2);
                        end
                    end
                    2'd2: begin
                        w_dreq.start = 1'b1;
                        w_dreq.num   = (r_rphi << 16) + w_den_cur;
                        w_dreq.den   = w_den_cur << 1;
                        n_cnt = (AW+1)'(3);
                    end
                    default: begin
                        if (w_drsp.done) begin
                            // q includes +1 bias from den offset
                            n_ophi = 16'((r_qphi - 64'd1) * 64'd32768 + w_drsp.quo
                                     - 64'd32768);
                            n_cnt  = '0;
                            n_st   = hdhp_pkg::ST_DIV_CT;
                        end
                    end
                endcase
            end
            hdhp_pkg::ST_DIV_CT: begin
                w_den_cur = w_dct;
                unique case (r_cnt[1:0])
                    2'd0: begin
                        w_dreq.start = 1'b1;
                        w_dreq.num   = w_nct;
                        w_dreq.den   = w_den_cur;
                        n_cnt = (AW+1)'(1);
                    end
                    2'd1: begin
                        if (w_drsp.done) begin
                            n_qct = w_drsp.quo;
                            n_rct = w_drsp.rem;
                            n_cnt = (AW+1)'(2);
                        end
                    end
                    2'd2: begin
                        w_dreq.start = 1'b1;
                        w_dreq.num   = (r_rct << 16) + w_den_cur;
                        w_dreq.den   = w_den_cur << 1;
                        n_cnt = (AW+1)'(3);
                    end
                    default: begin
                        if (w_drsp.done) begin
                            // value = (q-1)*32768 + frac - 32768, >= -65536
                            if ((r_qct * 64'd32768 + w_drsp.quo) < 64'd32768) begin
                                n_oct = -16'sd32768;
                            end else if ((r_qct * 64'd32768 + w_drsp.quo)
                                         > 64'd98303) begin
                                n_oct = 16'sd32767;
                            end else begin
                                n_oct = 16'(r_qct * 64'd32768 + w_drsp.quo
                                        - 64'd65536);
                            end
                            n_cnt = '0;
                            n_st  = hdhp_pkg::ST_DIV_H;
                        end
                    end
                endcase
            end
            hdhp_pkg::ST_DIV_H: begin
                if (r_cnt[0] == 1'b0) begin
                    w_dreq.start = 1'b1;
                    w_dreq.num   = 64'(r_sw);
                    w_dreq.den   = 64'(r_sn);
                    n_cnt = (AW+1)'(1);
                end else if (w_drsp.done) begin
                    n_oh  = (w_drsp.quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                         : w_drsp.quo[31:0];
                    n_of  = 1'b1;
                    n_st  = hdhp_pkg::ST_DONE;
                end
            end
            hdhp_pkg::ST_DONE: begin
                n_ov = 1'b1;
                if (!r_of) begin
                    n_ophi = '0;
                    n_oct  = '0;
                    n_oh   = '0;
                end
                n_st = hdhp_pkg::ST_IDLE;
            end
            default: n_st = hdhp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= hdhp_pkg::ST_CLEAR;   // clearing pass after reset
            r_cnt  <= '0;
            r_ecnt <= '0;
            r_wtot <= '0;
            r_ov   <= 1'b0;
            r_pv   <= 1'b0;
            r_of   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_cnt  <= n_cnt;
            r_ecnt <= n_ecnt;
            r_wtot <= n_wtot;
            r_ov   <= n_ov;
            r_pv   <= n_pv;
            r_of   <= n_of;
        end
        r_addr <= n_addr;
        r_w    <= n_w;
        r_best <= n_best;
        r_bidx <= n_bidx;
        r_pidx <= n_pidx;
        r_pdx  <= n_pdx;
        r_pdy  <= n_pdy;
        r_sw   <= n_sw;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_sn   <= n_sn;
        r_qphi <= n_qphi;
        r_rphi <= n_rphi;
        r_qct  <= n_qct;
        r_rct  <= n_rct;
        r_ophi <= n_ophi;
        r_oct  <= n_oct;
        r_oh   <= n_oh;
    end

    assign o_valid         = r_ov;
    assign o_peak_phi      = r_ophi;
    assign o_peak_costheta = r_oct;
    assign o_peak_height   = r_oh;
    assign o_found         = r_ov & r_of;

`ifndef SYNTH
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |=> !r_ov) else $error("result beat longer than one cycle");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_st == hdhp_pkg::ST_IDLE)) else $error("result outside idle");
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_of) |-> (r_oh == 32'd0 && r_ophi == 16'sd0))
        else $error("empty result not zero");
    a_win_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == hdhp_pkg::ST_DIV_PHI) |-> (r_sn >= 5'd3 && r_sn <= 5'd25))
        else $error("window bin count out of range");
`endif
endmodule
`default_nettype wire
